// ----- design/pps_pkg.sv -----
// Shared constants, control word types and microcode table of the program schedule generator.
`timescale 1ns / 1ps

package pps_pkg;

  // Default configuration
  localparam int NUM_REGS_DEF  = 32;
  localparam int NUM_LANES_DEF = 16;
  localparam int MATH_OPS_DEF  = 18;
  localparam int CACHE_OPS_DEF = 11;

  // Field widths
  localparam int SEED_W      = 64;
  localparam int WORD_W      = 32;
  localparam int KIND_W      = 2;
  localparam int IDX_W       = 5;
  localparam int REG_FIELD_W = 5;
  localparam int LANE_FIELD_W = 4;
  localparam int OUT_FIELDS_W = IDX_W + 2 * REG_FIELD_W + 2 * WORD_W + LANE_FIELD_W;
  localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELDS_W;

  // Remainder unit digit size
  localparam int CHUNK_W    = 8;
  localparam int NUM_CHUNKS = WORD_W / CHUNK_W;
  localparam int CHUNK_CNT_W = $clog2(NUM_CHUNKS);

  // FNV-1a and KISS99 constants
  localparam logic [WORD_W-1:0] FNV_BASIS  = 32'h811c_9dc5;
  localparam logic [WORD_W-1:0] FNV_PRIME  = 32'h0100_0193;
  localparam logic [WORD_W-1:0] KISS_Z_MUL = 32'd36969;
  localparam logic [WORD_W-1:0] KISS_W_MUL = 32'd18000;
  localparam logic [WORD_W-1:0] KISS_C_MUL = 32'd69069;
  localparam logic [WORD_W-1:0] KISS_C_ADD = 32'd1234567;

  // Entry kinds
  localparam logic [KIND_W-1:0] KIND_MATH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CACHE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LANE  = 2'd2;

  // Sequencer branch conditions
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] COND_NEXT     = 3'd0;
  localparam logic [COND_W-1:0] COND_JUMP     = 3'd1;
  localparam logic [COND_W-1:0] COND_HOLD_IN  = 3'd2;
  localparam logic [COND_W-1:0] COND_HOLD_MOD = 3'd3;
  localparam logic [COND_W-1:0] COND_SEARCH   = 3'd4;
  localparam logic [COND_W-1:0] COND_PICK     = 3'd5;
  localparam logic [COND_W-1:0] COND_EMIT     = 3'd6;
  localparam logic [COND_W-1:0] COND_EMIT_END = 3'd7;

  // Program addresses
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] ST_IDLE      = 5'd0;
  localparam logic [STEP_W-1:0] ST_HASH0     = 5'd1;
  localparam logic [STEP_W-1:0] ST_HASH1     = 5'd2;
  localparam logic [STEP_W-1:0] ST_HASH2     = 5'd3;
  localparam logic [STEP_W-1:0] ST_HASH3     = 5'd4;
  localparam logic [STEP_W-1:0] ST_MATH      = 5'd5;
  localparam logic [STEP_W-1:0] ST_M_MOD     = 5'd6;
  localparam logic [STEP_W-1:0] ST_M_WAIT    = 5'd7;
  localparam logic [STEP_W-1:0] ST_M_SEARCH  = 5'd8;
  localparam logic [STEP_W-1:0] ST_M_FRESH   = 5'd9;
  localparam logic [STEP_W-1:0] ST_M_FMOD    = 5'd10;
  localparam logic [STEP_W-1:0] ST_M_FWAIT   = 5'd11;
  localparam logic [STEP_W-1:0] ST_PICK_DONE = 5'd12;
  localparam logic [STEP_W-1:0] ST_M_DRAW_A  = 5'd13;
  localparam logic [STEP_W-1:0] ST_M_LAT_A   = 5'd14;
  localparam logic [STEP_W-1:0] ST_M_LAT_B   = 5'd15;
  localparam logic [STEP_W-1:0] ST_M_EMIT    = 5'd16;
  localparam logic [STEP_W-1:0] ST_CACHE     = 5'd17;
  localparam logic [STEP_W-1:0] ST_C_MOD     = 5'd18;
  localparam logic [STEP_W-1:0] ST_C_WAIT    = 5'd19;
  localparam logic [STEP_W-1:0] ST_C_DRAW_A  = 5'd20;
  localparam logic [STEP_W-1:0] ST_C_LAT_A   = 5'd21;
  localparam logic [STEP_W-1:0] ST_C_EMIT    = 5'd22;
  localparam logic [STEP_W-1:0] ST_LANE      = 5'd23;
  localparam logic [STEP_W-1:0] ST_L_MOD     = 5'd24;
  localparam logic [STEP_W-1:0] ST_L_WAIT    = 5'd25;
  localparam logic [STEP_W-1:0] ST_L_EMIT    = 5'd26;

  // One control word per program step
  typedef struct packed {
    logic              hash;
    logic [1:0]        hash_idx;
    logic              draw;
    logic              mod_start;
    logic              mod_lane;
    logic              cand_load;
    logic              search;
    logic              mark_fresh;
    logic              pick_toggle;
    logic              lat_a;
    logic              lat_b;
    logic              lat_src;
    logic              lat_lane;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic              sched_clr;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic in_fire;
    logic mod_done;
    logic hit;
    logic exhausted;
    logic pick_sel;
    logic more;
    logic out_free;
  } status_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '0;
    case (step)
      ST_IDLE: begin
        c.cond = COND_HOLD_IN;
      end
      ST_HASH0: begin
        c.hash     = 1'b1;
        c.hash_idx = 2'd0;
      end
      ST_HASH1: begin
        c.hash     = 1'b1;
        c.hash_idx = 2'd1;
      end
      ST_HASH2: begin
        c.hash     = 1'b1;
        c.hash_idx = 2'd2;
      end
      ST_HASH3: begin
        c.hash      = 1'b1;
        c.hash_idx  = 2'd3;
        c.sched_clr = 1'b1;
      end
      ST_MATH: begin
        c.draw = 1'b1;
      end
      ST_M_MOD: begin
        c.mod_start = 1'b1;
      end
      ST_M_WAIT: begin
        c.cand_load = 1'b1;
        c.cond      = COND_HOLD_MOD;
      end
      ST_M_SEARCH: begin
        c.search = 1'b1;
        c.cond   = COND_SEARCH;
        c.target = ST_PICK_DONE;
      end
      ST_M_FRESH: begin
        c.draw = 1'b1;
      end
      ST_M_FMOD: begin
        c.mod_start = 1'b1;
      end
      ST_M_FWAIT: begin
        c.mark_fresh = 1'b1;
        c.cond       = COND_HOLD_MOD;
      end
      ST_PICK_DONE: begin
        c.pick_toggle = 1'b1;
        c.cond        = COND_PICK;
        c.target      = ST_MATH;
      end
      ST_M_DRAW_A: begin
        c.draw = 1'b1;
      end
      ST_M_LAT_A: begin
        c.lat_a = 1'b1;
        c.draw  = 1'b1;
      end
      ST_M_LAT_B: begin
        c.lat_b = 1'b1;
      end
      ST_M_EMIT: begin
        c.emit   = 1'b1;
        c.kind   = KIND_MATH;
        c.cond   = COND_EMIT;
        c.target = ST_MATH;
      end
      ST_CACHE: begin
        c.draw = 1'b1;
      end
      ST_C_MOD: begin
        c.mod_start = 1'b1;
      end
      ST_C_WAIT: begin
        c.lat_src = 1'b1;
        c.cond    = COND_HOLD_MOD;
      end
      ST_C_DRAW_A: begin
        c.draw = 1'b1;
      end
      ST_C_LAT_A: begin
        c.lat_a = 1'b1;
      end
      ST_C_EMIT: begin
        c.emit   = 1'b1;
        c.kind   = KIND_CACHE;
        c.cond   = COND_EMIT;
        c.target = ST_CACHE;
      end
      ST_LANE: begin
        c.draw = 1'b1;
      end
      ST_L_MOD: begin
        c.mod_start = 1'b1;
        c.mod_lane  = 1'b1;
      end
      ST_L_WAIT: begin
        c.lat_lane = 1'b1;
        c.cond     = COND_HOLD_MOD;
      end
      ST_L_EMIT: begin
        c.emit   = 1'b1;
        c.kind   = KIND_LANE;
        c.cond   = COND_EMIT_END;
        c.target = ST_IDLE;
      end
      default: begin
        c.cond   = COND_JUMP;
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- design/progpow_program_schedule_gen_core.sv -----
// Top level: seeds a KISS99 generator per program seed and streams the program schedule.
// The per-seed time grows with each extra used-mask probe and each mask refill, and with each
// remainder when NUM_REGS or NUM_LANES is no power of two; the microcode steps, the mask
// probe loop and the byte-serial remainder unit set it.
// One seed at a time; the next seed is taken while the last entry waits in the output register.
// Reset is asynchronous, active low: generator words, mask, counters and sequencer clear.
`timescale 1ns / 1ps

module progpow_program_schedule_gen_core import pps_pkg::*; #(
  parameter int NUM_REGS  = NUM_REGS_DEF,
  parameter int NUM_LANES = NUM_LANES_DEF,
  parameter int MATH_OPS  = MATH_OPS_DEF,
  parameter int CACHE_OPS = CACHE_OPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SEED_W-1:0]     s_axis_tdata,   // [63:0] program_seed
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [4:0] entry_index, [9:5] dest_register, [14:10] source_register,
  // [46:15] selector_a, [78:47] selector_b, [82:79] source_lane, [87:83] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [KIND_W-1:0]     m_axis_tuser,   // [1:0] entry_kind
  output logic                  m_axis_tlast    // last_entry
);

  localparam int MAX_MOD = (NUM_REGS > NUM_LANES) ? NUM_REGS : NUM_LANES;
  localparam int MOD_W   = $clog2(MAX_MOD);
  localparam int RW      = $clog2(NUM_REGS);
  localparam int LW      = $clog2(NUM_LANES);

  ctrl_t   ctrl;
  status_t stat;

  logic              in_fire;
  logic              out_free;
  logic              emit_fire;
  logic [WORD_W-1:0] rnd;
  logic              mod_done;
  logic [MOD_W-1:0]  mod_rem;
  logic              hit;
  logic              exhausted;
  logic              more;

  logic [SEED_W-1:0]   seed_q;
  logic [NUM_REGS-1:0] mask_q, mask_d;
  logic [RW-1:0]       cand_q, cand_d;
  logic [RW-1:0]       probe_q, probe_d;
  logic                pick_sel_q, pick_sel_d;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic [RW-1:0]       dest_q, dest_d;
  logic [RW-1:0]       src_q, src_d;
  logic [WORD_W-1:0]   sela_q, sela_d;
  logic [WORD_W-1:0]   selb_q, selb_d;
  logic [LW-1:0]       lane_q, lane_d;
  logic [RW-1:0]       pick_val;
  logic [NUM_REGS-1:0] cand_bit;
  logic [NUM_REGS-1:0] fresh_bit;

  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [KIND_W-1:0]     m_user_q;
  logic                  m_last_q;
  logic [IDX_W-1:0]        o_idx;
  logic [REG_FIELD_W-1:0]  o_dst, o_src;
  logic [WORD_W-1:0]       o_sela, o_selb;
  logic [LANE_FIELD_W-1:0] o_lane;

  pps_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  pps_rng u_rng (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hash_i     (ctrl.hash),
    .hash_idx_i (ctrl.hash_idx),
    .draw_i     (ctrl.draw),
    .seed_i     (seed_q),
    .rnd_o      (rnd)
  );

  pps_mod #(
    .NUM_REGS  (NUM_REGS),
    .NUM_LANES (NUM_LANES),
    .MOD_W     (MOD_W)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.mod_start),
    .lane_i  (ctrl.mod_lane),
    .value_i (rnd),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign s_axis_tready = (ctrl.cond == COND_HOLD_IN);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_valid_q | m_axis_tready;
  assign emit_fire     = ctrl.emit & out_free;

  // Circular probe of the used mask, one candidate per cycle
  assign cand_bit  = {{(NUM_REGS - 1){1'b0}}, 1'b1} << cand_q;
  assign fresh_bit = {{(NUM_REGS - 1){1'b0}}, 1'b1} << mod_rem[RW-1:0];
  assign hit       = ~mask_q[cand_q];
  assign exhausted = ~hit & (probe_q == RW'(NUM_REGS - 1));

  always_comb begin
    case (ctrl.kind)
      KIND_MATH:  more = (cnt_q != IDX_W'(MATH_OPS - 1));
      KIND_CACHE: more = (cnt_q != IDX_W'(CACHE_OPS - 1));
      default:    more = 1'b0;
    endcase
  end

  assign stat.in_fire   = in_fire;
  assign stat.mod_done  = mod_done;
  assign stat.hit       = hit;
  assign stat.exhausted = exhausted;
  assign stat.pick_sel  = pick_sel_q;
  assign stat.more      = more;
  assign stat.out_free  = out_free;

  always_comb begin
    mask_d     = mask_q;
    cand_d     = cand_q;
    probe_d    = probe_q;
    pick_sel_d = pick_sel_q;
    cnt_d      = cnt_q;
    dest_d     = dest_q;
    src_d      = src_q;
    sela_d     = sela_q;
    selb_d     = selb_q;
    lane_d     = lane_q;
    pick_val   = cand_q;

    if (ctrl.sched_clr) begin
      mask_d     = '0;
      cnt_d      = '0;
      pick_sel_d = 1'b0;
    end

    if (ctrl.cand_load) begin
      cand_d  = mod_rem[RW-1:0];
      probe_d = '0;
    end

    if (ctrl.search) begin
      if (hit) begin
        mask_d   = mask_q | cand_bit;
        pick_val = cand_q;
        if (pick_sel_q) begin
          src_d = pick_val;
        end else begin
          dest_d = pick_val;
        end
      end else if (exhausted) begin
        // every register taken: start over with a fresh draw
        mask_d = '0;
      end else begin
        cand_d  = (cand_q == RW'(NUM_REGS - 1)) ? '0 : cand_q + RW'(1);
        probe_d = probe_q + RW'(1);
      end
    end

    if (ctrl.mark_fresh && mod_done) begin
      mask_d   = fresh_bit;
      pick_val = mod_rem[RW-1:0];
      if (pick_sel_q) begin
        src_d = pick_val;
      end else begin
        dest_d = pick_val;
      end
    end

    if (ctrl.pick_toggle) begin
      pick_sel_d = ~pick_sel_q;
    end

    if (ctrl.lat_a) begin
      sela_d = rnd;
    end
    if (ctrl.lat_b) begin
      selb_d = rnd;
    end
    if (ctrl.lat_src) begin
      src_d = mod_rem[RW-1:0];
    end
    if (ctrl.lat_lane) begin
      lane_d = mod_rem[LW-1:0];
    end

    if (emit_fire) begin
      cnt_d = more ? cnt_q + IDX_W'(1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q     <= '0;
      cand_q     <= '0;
      probe_q    <= '0;
      pick_sel_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      mask_q     <= mask_d;
      cand_q     <= cand_d;
      probe_q    <= probe_d;
      pick_sel_q <= pick_sel_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      seed_q <= s_axis_tdata;
    end
    dest_q <= dest_d;
    src_q  <= src_d;
    sela_q <= sela_d;
    selb_q <= selb_d;
    lane_q <= lane_d;
  end

  // Zero the fields that do not belong to the entry kind
  always_comb begin
    o_idx  = cnt_q;
    o_dst  = REG_FIELD_W'(dest_q);
    o_src  = REG_FIELD_W'(src_q);
    o_sela = sela_q;
    o_selb = selb_q;
    o_lane = '0;
    case (ctrl.kind)
      KIND_MATH: begin
      end
      KIND_CACHE: begin
        o_dst  = '0;
        o_selb = '0;
      end
      default: begin
        o_idx  = '0;
        o_dst  = '0;
        o_src  = '0;
        o_sela = '0;
        o_selb = '0;
        o_lane = LANE_FIELD_W'(lane_q);
      end
    endcase
  end

  always_comb begin
    if (emit_fire) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      m_data_q <= {{OUT_PAD_W{1'b0}}, o_lane, o_selb, o_sela, o_src, o_dst, o_idx};
      m_user_q <= ctrl.kind;
      m_last_q <= (ctrl.kind == KIND_LANE);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// ----- design/pps_rng.sv -----
// KISS99 generator with chained FNV-1a seeding.
`timescale 1ns / 1ps

module pps_rng import pps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              hash_i,
  input  logic [1:0]        hash_idx_i,
  input  logic              draw_i,
  input  logic [SEED_W-1:0] seed_i,
  output logic [WORD_W-1:0] rnd_o
);

  logic [WORD_W-1:0] h_q, h_d;
  logic [WORD_W-1:0] z_q, z_d;
  logic [WORD_W-1:0] w_q, w_d;
  logic [WORD_W-1:0] s_q, s_d;
  logic [WORD_W-1:0] c_q, c_d;

  logic [WORD_W-1:0] h_in, h_data, h_new;
  logic [WORD_W-1:0] z_step, w_step, c_step;
  logic [WORD_W-1:0] s1, s2, s3;

  // Chain starts from the offset basis; odd steps absorb the high word
  assign h_in   = (hash_idx_i == 2'd0) ? FNV_BASIS : h_q;
  assign h_data = hash_idx_i[0] ? seed_i[SEED_W-1:WORD_W] : seed_i[WORD_W-1:0];
  assign h_new  = (h_in ^ h_data) * FNV_PRIME;

  assign z_step = KISS_Z_MUL * {16'd0, z_q[15:0]} + {16'd0, z_q[31:16]};
  assign w_step = KISS_W_MUL * {16'd0, w_q[15:0]} + {16'd0, w_q[31:16]};
  assign c_step = KISS_C_MUL * c_q + KISS_C_ADD;
  assign s1     = s_q ^ (s_q << 17);
  assign s2     = s1 ^ (s1 >> 13);
  assign s3     = s2 ^ (s2 << 5);

  always_comb begin
    h_d = h_q;
    z_d = z_q;
    w_d = w_q;
    s_d = s_q;
    c_d = c_q;
    if (hash_i) begin
      h_d = h_new;
      case (hash_idx_i)
        2'd0:    z_d = h_new;
        2'd1:    w_d = h_new;
        2'd2:    s_d = h_new;
        default: c_d = h_new;
      endcase
    end else if (draw_i) begin
      z_d = z_step;
      w_d = w_step;
      s_d = s3;
      c_d = c_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= '0;
      z_q <= '0;
      w_q <= '0;
      s_q <= '0;
      c_q <= '0;
    end else begin
      h_q <= h_d;
      z_q <= z_d;
      w_q <= w_d;
      s_q <= s_d;
      c_q <= c_d;
    end
  end

  // Output of the most recent draw, taken from the advanced state
  assign rnd_o = ((({z_q[15:0], 16'd0}) + w_q) ^ c_q) + s_q;

endmodule

// ----- design/pps_mod.sv -----
// Remainder unit: draw mod reg/lane count, one byte per cycle; 2^n is masked.
`timescale 1ns / 1ps

module pps_mod import pps_pkg::*; #(
  parameter int NUM_REGS  = NUM_REGS_DEF,
  parameter int NUM_LANES = NUM_LANES_DEF,
  parameter int MOD_W     = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              lane_i,
  input  logic [WORD_W-1:0] value_i,
  output logic              done_o,
  output logic [MOD_W-1:0]  rem_o
);

  localparam logic [MOD_W:0]   REGS_N     = (MOD_W + 1)'(NUM_REGS);
  localparam logic [MOD_W:0]   LANES_N    = (MOD_W + 1)'(NUM_LANES);
  localparam logic [MOD_W-1:0] REGS_MASK  = MOD_W'(NUM_REGS - 1);
  localparam logic [MOD_W-1:0] LANES_MASK = MOD_W'(NUM_LANES - 1);
  localparam bit REGS_POW2  = (NUM_REGS & (NUM_REGS - 1)) == 0;
  localparam bit LANES_POW2 = (NUM_LANES & (NUM_LANES - 1)) == 0;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic                   sel_q, sel_d;
  logic [CHUNK_CNT_W-1:0] cnt_q, cnt_d;
  logic [WORD_W-1:0]      val_q, val_d;
  logic [MOD_W-1:0]       rem_q, rem_d;
  logic [MOD_W-1:0]       rem_step;
  logic [MOD_W:0]         modulus;
  logic                   start_pow2;

  assign modulus    = sel_q ? LANES_N : REGS_N;
  assign start_pow2 = lane_i ? LANES_POW2 : REGS_POW2;

  // Fold one byte of the value into the remainder, MSB first
  always_comb begin
    logic [MOD_W:0]   t;
    logic [MOD_W-1:0] r;
    r = rem_q;
    for (int k = 0; k < CHUNK_W; k++) begin
      t = {r, val_q[WORD_W-1-k]};
      if (t >= modulus) begin
        t = t - modulus;
      end
      r = t[MOD_W-1:0];
    end
    rem_step = r;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sel_d  = sel_q;
    cnt_d  = cnt_q;
    val_d  = val_q;
    rem_d  = rem_q;
    if (start_i) begin
      sel_d = lane_i;
      if (start_pow2) begin
        rem_d  = value_i[MOD_W-1:0] & (lane_i ? LANES_MASK : REGS_MASK);
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        cnt_d  = '0;
        val_d  = value_i;
        rem_d  = '0;
      end
    end else if (busy_q) begin
      rem_d = rem_step;
      val_d = {val_q[WORD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
      cnt_d = cnt_q + CHUNK_CNT_W'(1);
      if (cnt_q == CHUNK_CNT_W'(NUM_CHUNKS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sel_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      sel_q  <= sel_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- design/pps_seq.sv -----
// Microcode sequencer: step counter, control store and branch logic.
`timescale 1ns / 1ps

module pps_seq import pps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t stat_i,
  output ctrl_t   ctrl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] step_inc;
  ctrl_t             ctrl;

  assign ctrl     = ucode(step_q);
  assign step_inc = step_q + STEP_W'(1);

  always_comb begin
    case (ctrl.cond)
      COND_NEXT:     step_d = step_inc;
      COND_JUMP:     step_d = ctrl.target;
      COND_HOLD_IN:  step_d = stat_i.in_fire ? step_inc : step_q;
      COND_HOLD_MOD: step_d = stat_i.mod_done ? step_inc : step_q;
      COND_SEARCH: begin
        if (stat_i.hit) begin
          step_d = ctrl.target;
        end else if (stat_i.exhausted) begin
          step_d = step_inc;
        end else begin
          step_d = step_q;
        end
      end
      COND_PICK:     step_d = stat_i.pick_sel ? step_inc : ctrl.target;
      COND_EMIT: begin
        if (!stat_i.out_free) begin
          step_d = step_q;
        end else if (stat_i.more) begin
          step_d = ctrl.target;
        end else begin
          step_d = step_inc;
        end
      end
      COND_EMIT_END: step_d = stat_i.out_free ? ctrl.target : step_q;
      default:       step_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule
